// File: design/sacl_pkg.sv
// Shared constants, codes and types of the set-associative LRU cache model.
package sacl_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 32;

    // Fixed widths of the configuration registers and result fields.
    localparam int SET_BITS_W   = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_CFG_W   = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int TOTAL_W      = 32;
    localparam int OUT_TAG_W    = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Entries in the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_FETCH  = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SET_BITS   = 2'd0,
        REG_BLOCK_BITS = 2'd1,
        REG_WAYS       = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REREAD,
        ST_UPDATE
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: design/sacl_queue.sv
// Small first-in first-out queue between the front and the back of the cache.
module sacl_queue
    import sacl_pkg::*;
#(
    parameter int WIDTH = 41
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output queue_status_t    status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// File: design/sacl_front.sv
// Front end: accepts words, drops fetches, splits the address into set and tag.
module sacl_front
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
)
(
    input  logic                    start,
    input  logic [1:0]              operation,
    input  logic [ADDR_WIDTH-1:0]   address,
    input  logic [SET_BITS_W-1:0]   set_bits_eff,
    input  logic [BLOCK_BITS_W-1:0] block_bits,
    input  queue_status_t           q_status,
    input  logic                    clearing,
    output logic                    busy,
    output logic                    push,
    output logic [ADDR_WIDTH + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1):0] push_data
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SUM_W = $clog2((1 << BLOCK_BITS_W) + MAX_SET_BITS);
    localparam logic [SUM_W:0] ADDR_LIMIT = (SUM_W + 1)'(ADDR_WIDTH);

    logic [SUM_W-1:0]      shift_sum;
    logic [ADDR_WIDTH-1:0] block_addr;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag;
    logic                  accept;
    logic                  is_modify;

    always_comb
    begin
        shift_sum  = SUM_W'(block_bits) + SUM_W'(set_bits_eff);
        block_addr = address >> block_bits;
        set_mask   = ~({SET_W{1'b1}} << set_bits_eff);
        set_idx    = block_addr[SET_W-1:0] & set_mask;
        // Tag is zero once the index and offset cover the whole address.
        if ({1'b0, shift_sum} >= ADDR_LIMIT)
        begin
            tag = '0;
        end
        else
        begin
            tag = address >> shift_sum;
        end
    end

    assign busy      = q_status.full || clearing;
    assign accept    = start && !busy;
    assign is_modify = (op_t'(operation) == OP_MODIFY);
    assign push      = accept && (op_t'(operation) != OP_FETCH);
    assign push_data = {is_modify, set_idx, tag};

endmodule

// File: design/sacl_back.sv
// Back end: set memory, LRU update, running totals and the result word.
module sacl_back
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  queue_status_t                        q_status,
    input  logic [ADDR_WIDTH + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1):0] head,
    input  logic [$clog2(MAX_WAYS + 1)-1:0]      ways_eff,
    output logic                                 pop,
    output logic                                 clearing,
    output logic                                 result_valid,
    output logic                                 hit,
    output logic                                 missed,
    output logic                                 evicted,
    output logic [OUT_TAG_W-1:0]                 evicted_tag,
    output logic                                 last,
    output logic [TOTAL_W-1:0]                   hits_total,
    output logic [TOTAL_W-1:0]                   misses_total,
    output logic [TOTAL_W-1:0]                   evictions_total
);

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_ROWS = 1 << SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
    localparam logic [AGE_W:0]   AGE_NONE = (AGE_W + 1)'(MAX_WAYS);

    // Set memory, one row per set.
    logic [MAX_WAYS-1:0]                 valid_mem [NUM_ROWS];
    logic [MAX_WAYS-1:0][AGE_W-1:0]      age_mem   [NUM_ROWS];
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem   [NUM_ROWS];

    logic [MAX_WAYS-1:0]                 rd_valid_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_age_reg;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag_reg;

    back_state_t           state_reg, state_next;
    logic [SET_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]      cur_set_reg, cur_set_next;
    logic [ADDR_WIDTH-1:0] cur_tag_reg, cur_tag_next;
    logic                  second_reg, second_next;

    logic                  res_valid_reg;
    logic                  hit_reg, missed_reg, evicted_reg, last_reg;
    logic [OUT_TAG_W-1:0]  ev_tag_reg;
    logic [TOTAL_W-1:0]    hit_cnt_reg, miss_cnt_reg, ev_cnt_reg;

    // Memory port controls.
    logic                                mem_we;
    logic                                tag_we;
    logic [SET_W-1:0]                    raddr;
    logic [SET_W-1:0]                    waddr;
    logic [MAX_WAYS-1:0]                 wvalid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      wage;
    logic                                emit;

    // Lookup and replacement.
    logic [MAX_WAYS-1:0]                 in_use;
    logic                                u_hit;
    logic                                u_has_inv;
    logic [WAY_W-1:0]                    hit_way;
    logic [WAY_W-1:0]                    inv_way;
    logic [WAY_W-1:0]                    victim;
    logic [AGE_W-1:0]                    best_age;
    logic [WAY_W-1:0]                    target;
    logic [AGE_W:0]                      old_age;
    logic [MAX_WAYS-1:0]                 new_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      new_age;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tag;
    logic                                u_evict;
    logic [ADDR_WIDTH-1:0]               u_ev_tag;
    logic [OUT_TAG_W+ADDR_WIDTH-1:0]     ev_tag_ext;

    always_comb
    begin
        hit_way   = '0;
        inv_way   = '0;
        u_hit     = 1'b0;
        u_has_inv = 1'b0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            in_use[w] = (w < int'(ways_eff));
            if (in_use[w] && rd_valid_reg[w] && (rd_tag_reg[w] == cur_tag_reg))
            begin
                u_hit   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (in_use[w] && !rd_valid_reg[w])
            begin
                u_has_inv = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end

        // Oldest way, lowest index on a tie.
        victim   = '0;
        best_age = rd_age_reg[0];
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && (rd_age_reg[w] > best_age))
            begin
                victim   = WAY_W'(w);
                best_age = rd_age_reg[w];
            end
        end

        if (u_hit)
        begin
            target = hit_way;
        end
        else if (u_has_inv)
        begin
            target = inv_way;
        end
        else
        begin
            target = victim;
        end

        old_age = rd_valid_reg[target] ? {1'b0, rd_age_reg[target]} : AGE_NONE;

        new_valid = rd_valid_reg;
        new_tag   = rd_tag_reg;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            new_age[j] = rd_age_reg[j];
            if (j == int'(target))
            begin
                new_age[j]   = '0;
                new_valid[j] = 1'b1;
                new_tag[j]   = cur_tag_reg;
            end
            else if (in_use[j] && rd_valid_reg[j] && ({1'b0, rd_age_reg[j]} < old_age)
                     && (rd_age_reg[j] < AGE_MAX))
            begin
                new_age[j] = rd_age_reg[j] + 1'b1;
            end
        end

        u_evict    = !u_hit && !u_has_inv;
        u_ev_tag   = u_evict ? rd_tag_reg[victim] : '0;
        ev_tag_ext = {{OUT_TAG_W{1'b0}}, u_ev_tag};
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SET_W'(NUM_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_REREAD:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = second_reg ? ST_REREAD : ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        tag_we   = 1'b0;
        emit     = 1'b0;
        clearing = 1'b0;
        raddr    = cur_set_reg;
        waddr    = cur_set_reg;
        wvalid   = new_valid;
        wage     = new_age;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                mem_we   = 1'b1;
                waddr    = clr_cnt_reg;
                wvalid   = '0;
                wage     = '0;
            end
            ST_IDLE:
            begin
                pop   = !q_status.empty;
                raddr = head[ADDR_WIDTH +: SET_W];
            end
            ST_REREAD:
            begin
                raddr = cur_set_reg;
            end
            ST_UPDATE:
            begin
                mem_we = 1'b1;
                tag_we = 1'b1;
                emit   = 1'b1;
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        cur_set_next = cur_set_reg;
        cur_tag_next = cur_tag_reg;
        second_next  = second_reg;
        if (pop)
        begin
            cur_set_next = head[ADDR_WIDTH +: SET_W];
            cur_tag_next = head[ADDR_WIDTH-1:0];
            second_next  = head[ADDR_WIDTH + SET_W];
        end
        else if (emit)
        begin
            second_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            second_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            ev_cnt_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            second_reg    <= second_next;
            res_valid_reg <= emit;
            if (emit && u_hit && (hit_cnt_reg != TOTAL_MAX))
            begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (emit && !u_hit && (miss_cnt_reg != TOTAL_MAX))
            begin
                miss_cnt_reg <= miss_cnt_reg + 1'b1;
            end
            if (emit && u_evict && (ev_cnt_reg != TOTAL_MAX))
            begin
                ev_cnt_reg <= ev_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_set_reg <= cur_set_next;
        cur_tag_reg <= cur_tag_next;
        if (emit)
        begin
            hit_reg     <= u_hit;
            missed_reg  <= !u_hit;
            evicted_reg <= u_evict;
            ev_tag_reg  <= ev_tag_ext[OUT_TAG_W-1:0];
            last_reg    <= !second_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            valid_mem[waddr] <= wvalid;
            age_mem[waddr]   <= wage;
        end
        if (tag_we)
        begin
            tag_mem[waddr] <= new_tag;
        end
        rd_valid_reg <= valid_mem[raddr];
        rd_age_reg   <= age_mem[raddr];
        rd_tag_reg   <= tag_mem[raddr];
    end

    assign result_valid    = res_valid_reg;
    assign hit             = hit_reg;
    assign missed          = missed_reg;
    assign evicted         = evicted_reg;
    assign evicted_tag     = ev_tag_reg;
    assign last            = last_reg;
    assign hits_total      = hit_cnt_reg;
    assign misses_total    = miss_cnt_reg;
    assign evictions_total = ev_cnt_reg;

endmodule

// File: design/set_assoc_lru_cache_sim.sv
// Top level of the tag-only set-associative cache with true LRU replacement.
//
// Usage. An access word (operation, address) is taken at a rising edge where
// start is high and busy is low. Loads and stores make one cache access, a
// modify makes two accesses to the same address, and an instruction fetch is
// dropped at the front and produces nothing. Each access produces one result
// word, shown for exactly one cycle while result_valid is high; last marks the
// final word of an input. The receiver cannot stall, so results never wait.
// Configuration goes through its own channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high, and registers are to be
// changed only while the cache is idle.
// Flow. The front splits the address in the cycle of acceptance and queues
// it. For each access the back reads the set row from the set memory, then
// updates it and writes it back; a modify does this twice. For an idle cache
// the word passes through the queue entry, the row read register and the
// result register before its result shows. While the queue holds work the
// front keeps taking words; busy rises only when the queue is full or clearing.
// Reset. After reset the back sweeps the set memory once, one set per cycle,
// clearing the valid bits and ages of all 2**MAX_SET_BITS sets (256 by default),
// with busy held high. Totals restart at zero and saturate at their maximum.
module set_assoc_lru_cache_sim
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             operation,
    input  logic [ADDR_WIDTH-1:0]  address,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   result_valid,
    output logic                   hit,
    output logic                   missed,
    output logic                   evicted,
    output logic [OUT_TAG_W-1:0]   evicted_tag,
    output logic                   last,
    output logic [TOTAL_W-1:0]     hits_total,
    output logic [TOTAL_W-1:0]     misses_total,
    output logic [TOTAL_W-1:0]     evictions_total
);

    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ENTRY_W = ADDR_WIDTH + SET_W + 1;
    localparam int WAYS_W  = $clog2(MAX_WAYS + 1);

    // Configuration registers, in the raw form they are written.
    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_CFG_W-1:0]   ways_reg;

    // Effective values once out-of-range settings are clamped.
    logic [SET_BITS_W-1:0]   set_bits_eff;
    logic [WAYS_W-1:0]       ways_eff;

    logic                    push;
    logic [ENTRY_W-1:0]      push_data;
    logic                    pop;
    logic [ENTRY_W-1:0]      head;
    queue_status_t           q_status;
    logic                    clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            block_bits_reg <= '0;
            ways_reg       <= WAYS_CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                REG_WAYS:       ways_reg       <= cfg_data[WAYS_CFG_W-1:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // A set count beyond the memory is held at the memory's size; a way count
    // of zero means one way, and one beyond the ways built means all of them.
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            set_bits_eff = SET_BITS_W'(MAX_SET_BITS);
        end
        else
        begin
            set_bits_eff = set_bits_reg;
        end

        if (ways_reg == '0)
        begin
            ways_eff = WAYS_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYS_W'(ways_reg);
        end
    end

    sacl_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_front (
        .start        (start),
        .operation    (operation),
        .address      (address),
        .set_bits_eff (set_bits_eff),
        .block_bits   (block_bits_reg),
        .q_status     (q_status),
        .clearing     (clearing),
        .busy         (busy),
        .push         (push),
        .push_data    (push_data)
    );

    sacl_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    sacl_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .head            (head),
        .ways_eff        (ways_eff),
        .pop             (pop),
        .clearing        (clearing),
        .result_valid    (result_valid),
        .hit             (hit),
        .missed          (missed),
        .evicted         (evicted),
        .evicted_tag     (evicted_tag),
        .last            (last),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total)
    );

    // The back needs a read cycle before every update, so result words are
    // never on consecutive cycles.
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result words on consecutive cycles");

    // No result can come out while the set memory is being swept.
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !result_valid && busy)
        else $error("result or acceptance during the clearing sweep");

    // Every access either hits or misses, and only a miss can evict.
    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (hit != missed) && !(evicted && hit))
        else $error("inconsistent hit, miss and eviction flags");

    // The first word of a modify is followed by its second once the row is read again.
    a_modify_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> ##2 (result_valid && last))
        else $error("second access of a modify missing");

endmodule
